// ----- hw/rtl/igcd_pkg.sv -----
// Package for the integer GCD block: default operand width, controller state
// type and the command and status structs between controller and datapath.
// No dependencies.
package igcd_pkg;

  localparam int OPERAND_WIDTH = 63;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

endpackage

// ----- hw/rtl/integer_gcd.sv -----
// Integer GCD block: greatest common divisor of two unsigned operands, with a
// flag for a zero operand. Top level; depends on igcd_pkg, igcd_ctrl and
// igcd_datapath.
//
// Each transaction on the input channel gives exactly one transaction on the
// output channel. The operands are loaded into the operand registers and reduced
// by a binary shift-subtract unit that takes one step per cycle; every step
// removes at least one bit from one of the two operands. The result is then
// written to the result register once that register is free. Items are worked
// on one at a time; a new item is taken while the previous result still waits
// in the output register. A zero operand gives the other operand as the
// divisor (zero for two zeros) and raises zero_operand.
module integer_gcd #(
  parameter int OPERAND_WIDTH = igcd_pkg::OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OPERAND_WIDTH-1:0] first_operand,
  input  logic [OPERAND_WIDTH-1:0] second_operand,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OPERAND_WIDTH-1:0] divisor,
  output logic                     zero_operand
);

  igcd_pkg::cmd_t    cmd;
  igcd_pkg::status_t status;

  igcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  igcd_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .cmd            (cmd),
    .status         (status),
    .divisor        (divisor),
    .zero_operand   (zero_operand)
  );

endmodule

// ----- hw/rtl/igcd_datapath.sv -----
// Datapath of the integer GCD block: operand registers, binary shift-subtract
// step, common power-of-two count and the result register.
// Depends on igcd_pkg for the command and status structs.
module igcd_datapath #(
  parameter int OPERAND_WIDTH = igcd_pkg::OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic [OPERAND_WIDTH-1:0] first_operand,
  input  logic [OPERAND_WIDTH-1:0] second_operand,
  input  igcd_pkg::cmd_t           cmd,
  output igcd_pkg::status_t        status,
  output logic [OPERAND_WIDTH-1:0] divisor,
  output logic                     zero_operand
);

  localparam int KW = $clog2(OPERAND_WIDTH);

  logic [OPERAND_WIDTH-1:0] a;
  logic [OPERAND_WIDTH-1:0] b;
  logic [KW-1:0]            k;
  logic                     zero_seen;

  logic [OPERAND_WIDTH-1:0] a_next;
  logic [OPERAND_WIDTH-1:0] b_next;
  logic [KW-1:0]            k_next;
  logic [OPERAND_WIDTH-1:0] diff_ab;
  logic [OPERAND_WIDTH-1:0] diff_ba;
  logic [OPERAND_WIDTH-1:0] gcd_value;

  assign diff_ab   = a - b;
  assign diff_ba   = b - a;
  assign gcd_value = (a | b) << k;
  assign status.done = (a == '0) || (b == '0);

  // One reduction step: strip common and single factors of two, otherwise
  // subtract the smaller odd value from the larger and halve the difference.
  always_comb begin
    a_next = a;
    b_next = b;
    k_next = k;
    if (!a[0] && !b[0]) begin
      a_next = a >> 1;
      b_next = b >> 1;
      k_next = k + 1'b1;
    end else if (!a[0]) begin
      a_next = a >> 1;
    end else if (!b[0]) begin
      b_next = b >> 1;
    end else if (a >= b) begin
      a_next = diff_ab >> 1;
    end else begin
      b_next = diff_ba >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a         <= first_operand;
      b         <= second_operand;
      k         <= '0;
      zero_seen <= (first_operand == '0) || (second_operand == '0);
    end else if (cmd.step) begin
      a <= a_next;
      b <= b_next;
      k <= k_next;
    end
    if (cmd.emit) begin
      divisor      <= gcd_value;
      zero_operand <= zero_seen;
    end
  end

endmodule

// ----- hw/rtl/igcd_ctrl.sv -----
// Controller of the integer GCD block: input and output handshakes, run state
// and result valid flag.
// Depends on igcd_pkg for the state type and the command and status structs.
module igcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  igcd_pkg::status_t status,
  output igcd_pkg::cmd_t    cmd
);

  igcd_pkg::ctrl_state_t state;
  igcd_pkg::ctrl_state_t state_next;
  logic                  out_valid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      igcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = igcd_pkg::ST_RUN;
        end
      end
      igcd_pkg::ST_RUN: begin
        if (status.done && (!out_valid || out_ready)) begin
          state_next = igcd_pkg::ST_IDLE;
        end
      end
      default: state_next = igcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      igcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      igcd_pkg::ST_RUN: begin
        cmd.step = !status.done;
        cmd.emit = status.done && (!out_valid || out_ready);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= igcd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
